// File: hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// types, sizes and helper functions of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int TOP_BLOCKS      = 32;
   localparam int NUM_ORDERS      = 11;
   localparam int MIN_BLOCK_BYTES = 128;
   localparam int TOP_ORDER       = NUM_ORDERS - 1;
   localparam int MIN_BLOCKS      = TOP_BLOCKS << TOP_ORDER;
   localparam int MAP_DEPTH       = TOP_BLOCKS * ((1 << NUM_ORDERS) - 1);
   localparam int HEAP_BYTES      = MIN_BLOCKS * MIN_BLOCK_BYTES;
   localparam int MAX_REQUEST     = 100000000;
   localparam int HEADER_RESET    = 32;
   localparam int WORD_BITS       = 64;
   localparam int WORD_LSB        = $clog2(WORD_BITS);
   localparam int MAP_WORDS       = (MAP_DEPTH + WORD_BITS - 1) / WORD_BITS;
   localparam int MAP_AW          = $clog2(MAP_WORDS);
   localparam int TAG_AW          = $clog2(MIN_BLOCKS);
   localparam int OFS_W           = TAG_AW - WORD_LSB;
   localparam int ORD_W           = 4;
   localparam int BLK_LSB         = $clog2(MIN_BLOCK_BYTES);
   localparam int TOP_BYTES       = MIN_BLOCK_BYTES << TOP_ORDER;
   localparam int BYTES_W         = $clog2(TOP_BYTES) + 1;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_SIZE = 3'd1,
      ST_TOO_BIG  = 3'd2,
      ST_NO_MEM   = 3'd3,
      ST_BAD_FREE = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_SPLIT_RD,
      S_SPLIT_WR,
      S_TAG,
      S_FTAG,
      S_MREAD,
      S_MCHK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic        kind;
      logic [26:0] request_size;
      logic [21:0] release_addr;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [21:0] block_addr;
      logic [3:0]  block_order;
      logic [15:0] free_blocks;
      logic [22:0] free_bytes;
      logic [15:0] used_blocks;
      logic [22:0] used_bytes;
   } rsp_type;

   function automatic logic [MAP_AW-1:0] base_word(input logic [ORD_W-1:0] o);
      int b;
      b = TOP_BLOCKS * ((1 << NUM_ORDERS) - (1 << (NUM_ORDERS - int'(o))));
      return MAP_AW'(b >> WORD_LSB);
   endfunction

   function automatic logic [OFS_W-1:0] last_word(input logic [ORD_W-1:0] o);
      int n;
      n = TOP_BLOCKS << (TOP_ORDER - int'(o));
      return OFS_W'(((n + WORD_BITS - 1) >> WORD_LSB) - 1);
   endfunction

   function automatic logic [BYTES_W-1:0] block_bytes(input logic [ORD_W-1:0] o);
      return BYTES_W'(MIN_BLOCK_BYTES) << o;
   endfunction

   function automatic logic [WORD_BITS-1:0] init_word(input logic [MAP_AW-1:0] w);
      logic [WORD_BITS-1:0] r;
      int                   g;
      int                   top;
      r   = '0;
      top = TOP_BLOCKS * ((1 << NUM_ORDERS) - 2);
      for (int i = 0; i < WORD_BITS; i++) begin
         g    = int'(w) * WORD_BITS + i;
         r[i] = (g >= top) && (g < MAP_DEPTH);
      end
      return r;
   endfunction

endpackage

// File: hdl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// buddy allocator over 32 top blocks of 128 KiB, free bitmap and block tags
// held in on-chip memories
// ----------------------------------------------------------------------------
// After reset a clearing pass initializes the tag memory and the free
// bitmap; busy stays high meanwhile. A request beat is taken when start is
// high and busy low. An allocate scans the free bitmap one 64-bit word per
// cycle from the needed order upward (up to about 1000 words), then passes
// through a split read state and a split write state per split level; a
// free takes a tag read, then a map read and a merge check per merge level.
// Each result beat is shown on rsp_data for exactly one cycle with rsp_valid
// and cannot be held off. header_bytes is written through csr_we / csr_wdata.
module buddy_block_allocator
   import bba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   input  logic       csr_we,
   input  logic [6:0] csr_wdata,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [4:0]           tag_mem [MIN_BLOCKS];

   state_type            state_ff, state_in;
   logic [TAG_AW-1:0]    clr_ff, clr_in;
   logic [6:0]           hdr_ff;
   logic [15:0]          fcnt_ff, fcnt_in, acnt_ff, acnt_in;
   logic [22:0]          fsum_ff, fsum_in;
   logic [ORD_W-1:0]     ord_ff, ord_in, first_ff, first_in, cur_j_ff, cur_j_in;
   logic [TAG_AW-1:0]    cur_idx_ff, cur_idx_in;
   logic [ORD_W-1:0]     scan_j_ff, scan_j_in, pend_j_ff, pend_j_in;
   logic [OFS_W-1:0]     scan_k_ff, scan_k_in, pend_k_ff, pend_k_in;
   logic                 pend_ff, pend_in;
   logic [2:0]           stat_ff, stat_in;
   logic [21:0]          addr_ff, addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 map_we;
   logic [MAP_AW-1:0]    map_waddr, map_raddr;
   logic [WORD_BITS-1:0] map_wdata, map_rdata_ff;
   logic                 tag_we;
   logic [TAG_AW-1:0]    tag_waddr, tag_raddr;
   logic [4:0]           tag_wdata, tag_rdata_ff;

   logic [27:0]          need;
   logic [ORD_W-1:0]     need_ord;
   logic [WORD_LSB-1:0]  pe;
   logic                 pe_hit;
   logic [ORD_W-1:0]     tord;
   logic [WORD_LSB-1:0]  bpos;
   logic [TAG_AW-1:0]    sidx;
   logic [22:0]          fprod, aprod;

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rdata_ff <= map_mem[map_raddr];
      if (tag_we) begin
         tag_mem[tag_waddr] <= tag_wdata;
      end
      tag_rdata_ff <= tag_mem[tag_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         hdr_ff       <= 7'(HEADER_RESET);
         fcnt_ff      <= 16'(TOP_BLOCKS);
         acnt_ff      <= 16'(TOP_BLOCKS);
         fsum_ff      <= 23'(HEAP_BYTES);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fcnt_ff      <= fcnt_in;
         acnt_ff      <= acnt_in;
         fsum_ff      <= fsum_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            hdr_ff <= csr_wdata;
         end
      end
      ord_ff     <= ord_in;
      first_ff   <= first_in;
      cur_j_ff   <= cur_j_in;
      cur_idx_ff <= cur_idx_in;
      scan_j_ff  <= scan_j_in;
      scan_k_ff  <= scan_k_in;
      pend_j_ff  <= pend_j_in;
      pend_k_ff  <= pend_k_in;
      stat_ff    <= stat_in;
      addr_ff    <= addr_in;
      rsp_ff     <= rsp_in;
   end

   // lowest set bit of the word read during the scan
   always_comb begin
      pe     = '0;
      pe_hit = 1'b0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (map_rdata_ff[i]) begin
            pe     = WORD_LSB'(i);
            pe_hit = 1'b1;
         end
      end
   end

   always_comb begin
      need     = 28'(req_data.request_size) + 28'(hdr_ff);
      need_ord = '0;
      for (int o = 0; o < TOP_ORDER; o++) begin
         if (28'(block_bytes(ORD_W'(o))) < need) begin
            need_ord = need_ord + 1'b1;
         end
      end
      tord = (tag_rdata_ff[3:0] > ORD_W'(TOP_ORDER)) ? ORD_W'(TOP_ORDER) : tag_rdata_ff[3:0];
      bpos  = cur_idx_ff[WORD_LSB-1:0];
      sidx  = cur_idx_ff << 1;
      fprod = 23'(fcnt_ff * hdr_ff);
      aprod = 23'(acnt_ff * hdr_ff);
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      fcnt_in      = fcnt_ff;
      acnt_in      = acnt_ff;
      fsum_in      = fsum_ff;
      ord_in       = ord_ff;
      first_in     = first_ff;
      cur_j_in     = cur_j_ff;
      cur_idx_in   = cur_idx_ff;
      scan_j_in    = scan_j_ff;
      scan_k_in    = scan_k_ff;
      pend_in      = 1'b0;
      pend_j_in    = scan_j_ff;
      pend_k_in    = scan_k_ff;
      stat_in      = stat_ff;
      addr_in      = addr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      map_we       = 1'b0;
      map_waddr    = '0;
      map_wdata    = map_rdata_ff;
      map_raddr    = '0;
      tag_we       = 1'b0;
      tag_waddr    = '0;
      tag_wdata    = '0;
      tag_raddr    = req_data.release_addr[21:BLK_LSB];
      busy         = (state_ff != S_IDLE);

      case (state_ff)
         S_CLEAR: begin
            tag_we    = 1'b1;
            tag_waddr = clr_ff;
            if (int'(clr_ff) < MAP_WORDS) begin
               map_we    = 1'b1;
               map_waddr = clr_ff[MAP_AW-1:0];
               map_wdata = init_word(clr_ff[MAP_AW-1:0]);
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == TAG_AW'(MIN_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               addr_in = '0;
               ord_in  = '0;
               if (req_data.kind) begin
                  if (req_data.release_addr[BLK_LSB-1:0] != '0) begin
                     stat_in  = ST_BAD_FREE;
                     state_in = S_DONE;
                  end else begin
                     addr_in  = req_data.release_addr;
                     state_in = S_FTAG;
                  end
               end else if (req_data.request_size == '0 ||
                            req_data.request_size > 27'(MAX_REQUEST)) begin
                  stat_in  = ST_BAD_SIZE;
                  state_in = S_DONE;
               end else if (need > 28'(TOP_BYTES)) begin
                  stat_in  = ST_TOO_BIG;
                  state_in = S_DONE;
               end else begin
                  ord_in    = need_ord;
                  scan_j_in = need_ord;
                  scan_k_in = '0;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (pend_ff && pe_hit) begin
               map_we     = 1'b1;
               map_waddr  = base_word(pend_j_ff) + MAP_AW'(pend_k_ff);
               map_wdata  = map_rdata_ff & ~(WORD_BITS'(1) << pe);
               cur_j_in   = pend_j_ff;
               cur_idx_in = {pend_k_ff, pe};
               state_in   = S_SPLIT_RD;
            end else if (scan_j_ff > ORD_W'(TOP_ORDER)) begin
               if (!pend_ff) begin
                  ord_in   = '0;
                  stat_in  = ST_NO_MEM;
                  state_in = S_DONE;
               end
            end else begin
               map_raddr = base_word(scan_j_ff) + MAP_AW'(scan_k_ff);
               pend_in   = 1'b1;
               if (scan_k_ff == last_word(scan_j_ff)) begin
                  scan_j_in = scan_j_ff + 1'b1;
                  scan_k_in = '0;
               end else begin
                  scan_k_in = scan_k_ff + 1'b1;
               end
            end
         end
         S_SPLIT_RD: begin
            if (cur_j_ff == ord_ff) begin
               state_in = S_TAG;
            end else begin
               cur_j_in   = cur_j_ff - 1'b1;
               cur_idx_in = sidx;
               map_raddr  = base_word(cur_j_ff - 1'b1) + MAP_AW'(sidx >> WORD_LSB);
               fcnt_in    = fcnt_ff + 1'b1;
               acnt_in    = acnt_ff + 1'b1;
               state_in   = S_SPLIT_WR;
            end
         end
         S_SPLIT_WR: begin
            map_we    = 1'b1;
            map_waddr = base_word(cur_j_ff) + MAP_AW'(cur_idx_ff >> WORD_LSB);
            map_wdata = map_rdata_ff | (WORD_BITS'(1) << (bpos | WORD_LSB'(1)));
            state_in  = S_SPLIT_RD;
         end
         S_TAG: begin
            tag_we    = 1'b1;
            tag_waddr = cur_idx_ff << ord_ff;
            tag_wdata = {1'b1, ord_ff};
            fcnt_in   = fcnt_ff - 1'b1;
            fsum_in   = fsum_ff - 23'(block_bytes(ord_ff));
            addr_in   = {cur_idx_ff << ord_ff, BLK_LSB'(0)};
            stat_in   = ST_OK;
            state_in  = S_DONE;
         end
         S_FTAG: begin
            if (!tag_rdata_ff[4]) begin
               addr_in  = '0;
               stat_in  = ST_BAD_FREE;
               state_in = S_DONE;
            end else begin
               tag_we     = 1'b1;
               tag_waddr  = addr_ff[21:BLK_LSB];
               tag_wdata  = '0;
               fsum_in    = fsum_ff + 23'(block_bytes(tord));
               fcnt_in    = fcnt_ff + 1'b1;
               first_in   = tord;
               cur_j_in   = tord;
               cur_idx_in = addr_ff[21:BLK_LSB] >> tord;
               state_in   = S_MREAD;
            end
         end
         S_MREAD: begin
            map_raddr = base_word(cur_j_ff) + MAP_AW'(cur_idx_ff >> WORD_LSB);
            state_in  = S_MCHK;
         end
         S_MCHK: begin
            map_we    = 1'b1;
            map_waddr = base_word(cur_j_ff) + MAP_AW'(cur_idx_ff >> WORD_LSB);
            if (cur_j_ff < ORD_W'(TOP_ORDER) && map_rdata_ff[bpos ^ WORD_LSB'(1)]) begin
               map_wdata  = map_rdata_ff & ~(WORD_BITS'(1) << (bpos ^ WORD_LSB'(1)));
               fcnt_in    = fcnt_ff - 1'b1;
               acnt_in    = acnt_ff - 1'b1;
               cur_idx_in = cur_idx_ff >> 1;
               cur_j_in   = cur_j_ff + 1'b1;
               state_in   = S_MREAD;
            end else begin
               map_wdata = map_rdata_ff | (WORD_BITS'(1) << bpos);
               ord_in    = first_ff;
               stat_in   = ST_OK;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            rsp_valid_in       = 1'b1;
            rsp_in.status      = stat_ff;
            rsp_in.block_addr  = addr_ff;
            rsp_in.block_order = ord_ff;
            rsp_in.free_blocks = fcnt_ff;
            rsp_in.free_bytes  = fsum_ff - fprod;
            rsp_in.used_blocks = acnt_ff;
            rsp_in.used_bytes  = 23'(HEAP_BYTES) - aprod;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
